@@ sv/mcs_pkg.sv @@
// Shared types and constants for the multiplexed compare scheduler.
package mcs_pkg;

  localparam int OPCODE_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int FIELD_W   = 32;
  localparam int GRACE_W   = 8;
  localparam int KIND_W    = 2;
  localparam int FIRED_W   = 3;
  localparam int S_TDATA_W = 72;  // 4 + 32 + 32 = 68 bits, padded to bytes
  localparam int M_TDATA_W = 40;  // 3 + 32 = 35 bits, padded to bytes
  localparam int M_PAD_W   = M_TDATA_W - FIRED_W - FIELD_W;

  localparam logic [GRACE_W-1:0] GRACE_RESET = 8'd4;

  // Log2 of how many grace periods behind now the match window reaches.
  localparam int FIRE_WINDOWS_LOG2 = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ARM_SCHED    = 3'd0,
    OP_ARM          = 3'd1,
    OP_DISARM_SCHED = 3'd2,
    OP_DISARM       = 3'd3,
    OP_MATCH        = 3'd4,
    OP_SCHEDULE     = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ENABLE   = 2'd1,
    KIND_DISABLE  = 2'd2,
    KIND_NOCHANGE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

@@ sv/mcs_target_ram.sv @@
// Target table memory: one write port, one registered read port.
module mcs_target_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/multiplexed_compare_scheduler.sv @@
// Top level: timer table multiplexed onto one hardware compare.
//
// Requests come in on the s_ channel: s_tuser carries the opcode, s_tdata the
// entry index, target and current counter value. Results leave on the m_
// channel: m_tuser is the result kind, m_tdata the fired entry and compare
// value, m_tlast closes the run of results belonging to one request.
// grace_period is set via cfg_wr_en/cfg_wr_data, by the user only while idle; not enforced.
//
// Targets sit in a one-port-read memory; armed flags are flip-flops. Arm and
// disarm write at the accept edge. Requests that reschedule or carry a match
// event then walk the table, one memory read per cycle, during which fires
// are marked and the nearest remaining target is tracked. After that one
// result leaves per cycle while the output is free: fired entries in index
// order, then the schedule result. Arm or disarm without scheduling skips
// the table walk.
// A new request is accepted once the previous run has been handed to the
// output register, even if its last result is still waiting there.
// A stalled receiver holds the output register and halts the result walk.
// Reset disarms every entry, clears the scheduled compare and sets the grace
// period to 4; the target memory is not cleared (unarmed entries are unused).
module multiplexed_compare_scheduler #(
  parameter int ENTRIES    = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          cfg_wr_en,
  input  logic [mcs_pkg::GRACE_W-1:0]   cfg_wr_data,   // grace_period
  // request channel
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mcs_pkg::S_TDATA_W-1:0] s_tdata,       // entry_index, target_value, now_count
  input  logic [mcs_pkg::OPCODE_W-1:0]  s_tuser,       // opcode
  // result channel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mcs_pkg::M_TDATA_W-1:0] m_tdata,       // fired_entry, compare_value
  output logic [mcs_pkg::KIND_W-1:0]    m_tuser,       // kind
  output logic                          m_tlast        // last
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WIDE_W = COUNT_BITS + mcs_pkg::FIRE_WINDOWS_LOG2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // ---------------------------------------------------------------- fields
  logic [mcs_pkg::INDEX_W-1:0] in_index;
  logic [mcs_pkg::FIELD_W-1:0] in_target;
  logic [mcs_pkg::FIELD_W-1:0] in_now;
  logic [COUNT_BITS-1:0]       in_target_c;
  logic [COUNT_BITS-1:0]       in_now_c;
  logic [COUNT_BITS-1:0]       grace_c;
  logic                        idx_ok;
  logic                        accept;

  assign in_index    = s_tdata[mcs_pkg::INDEX_W-1:0];
  assign in_target   = s_tdata[mcs_pkg::INDEX_W +: mcs_pkg::FIELD_W];
  assign in_now      = s_tdata[mcs_pkg::INDEX_W + mcs_pkg::FIELD_W +: mcs_pkg::FIELD_W];
  assign in_target_c = COUNT_BITS'(in_target);
  assign in_now_c    = COUNT_BITS'(in_now);
  assign idx_ok      = 32'(in_index) < ENTRIES;
  assign accept      = s_tvalid && s_tready;

  // --------------------------------------------------------------- registers
  mcs_pkg::state_t             state;
  logic [mcs_pkg::GRACE_W-1:0] grace;
  logic [ENTRIES-1:0]          armed;
  logic [ENTRIES-1:0]          fired_mask;
  logic [COUNT_BITS-1:0]       sched_cmp;
  logic [COUNT_BITS-1:0]       now_q;
  logic [COUNT_BITS-1:0]       lax_q;
  logic                        is_match;
  logic                        do_sched;
  logic [CNT_W-1:0]            rd_cnt;
  logic                        ev_valid;
  logic [IDX_W-1:0]            ev_idx;
  logic [COUNT_BITS-1:0]       best;
  logic [COUNT_BITS-1:0]       pick;
  logic                        any_armed;

  assign s_tready = (state == mcs_pkg::ST_IDLE);

  // Decode at accept.
  logic arm_wr;
  logic disarm_wr;
  logic need_scan;

  always_comb begin
    arm_wr    = 1'b0;
    disarm_wr = 1'b0;
    need_scan = 1'b0;
    unique case (s_tuser) inside
      mcs_pkg::OP_ARM_SCHED: begin
        arm_wr    = idx_ok;
        need_scan = idx_ok;
      end
      mcs_pkg::OP_ARM: begin
        arm_wr = idx_ok;
      end
      mcs_pkg::OP_DISARM_SCHED: begin
        disarm_wr = idx_ok;
        need_scan = idx_ok;
      end
      mcs_pkg::OP_DISARM: begin
        disarm_wr = idx_ok;
      end
      mcs_pkg::OP_MATCH, mcs_pkg::OP_SCHEDULE: begin
        need_scan = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- memory
  logic                  rd_en;
  logic [COUNT_BITS-1:0] rd_data;

  assign rd_en = (state == mcs_pkg::ST_SCAN) && (rd_cnt < CNT_W'(ENTRIES));

  mcs_target_ram #(
    .DEPTH  (ENTRIES),
    .WIDTH  (COUNT_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && arm_wr),
    .wr_addr (IDX_W'(in_index)),
    .wr_data (in_target_c),
    .rd_en   (rd_en),
    .rd_addr (IDX_W'(rd_cnt)),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------- scan evaluation
  logic                  ev_armed;
  logic                  ev_fire;
  logic                  ev_live;
  logic [COUNT_BITS-1:0] ev_dist;
  logic [COUNT_BITS-1:0] ev_age;

  assign ev_armed = armed[ev_idx];
  assign ev_age   = now_q - rd_data;
  // Fire if the target is less than four grace periods behind now.
  assign ev_fire  = is_match && ev_armed &&
                    (WIDE_W'(ev_age) < WIDE_W'({grace, mcs_pkg::FIRE_WINDOWS_LOG2'(0)}));
  assign ev_live  = ev_armed && !ev_fire;
  assign ev_dist  = rd_data - lax_q;

  // ---------------------------------------------------------- result select
  logic                  out_free;
  logic [IDX_W-1:0]      first_fired;
  logic                  out_load;
  mcs_pkg::kind_t        res_kind;
  logic [IDX_W-1:0]      res_entry;
  logic [COUNT_BITS-1:0] res_value;
  logic                  res_last;
  logic                  sched_we;
  logic [COUNT_BITS-1:0] sched_next;
  logic [COUNT_BITS-1:0] earliest;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == mcs_pkg::ST_EMIT) && out_free;
  assign earliest = now_q + grace_c;
  assign grace_c  = COUNT_BITS'(grace);

  // lowest fired index goes first
  always_comb begin
    first_fired = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (fired_mask[i]) begin
        first_fired = IDX_W'(i);
      end
    end
  end

  always_comb begin
    res_kind   = mcs_pkg::KIND_NOCHANGE;
    res_entry  = '0;
    res_value  = '0;
    res_last   = 1'b1;
    sched_we   = 1'b0;
    sched_next = pick;
    if (fired_mask != '0) begin
      res_kind  = mcs_pkg::KIND_FIRED;
      res_entry = first_fired;
      res_last  = 1'b0;
    end else if (do_sched) begin
      if (!any_armed) begin
        // nothing armed: park the compare two grace periods back
        sched_we   = 1'b1;
        sched_next = lax_q - grace_c;
        res_kind   = mcs_pkg::KIND_DISABLE;
      end else if (pick != sched_cmp) begin
        // best holds pick - lax; clamp to at least now + grace
        sched_we = 1'b1;
        if ((earliest - lax_q) > best) begin
          sched_next = earliest;
        end
        res_kind  = mcs_pkg::KIND_ENABLE;
        res_value = sched_next;
      end
    end
  end

  // ------------------------------------------------------------------ control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mcs_pkg::ST_IDLE;
      grace      <= mcs_pkg::GRACE_RESET;
      armed      <= '0;
      fired_mask <= '0;
      sched_cmp  <= '0;
      rd_cnt     <= '0;
      ev_valid   <= 1'b0;
      ev_idx     <= '0;
      is_match   <= 1'b0;
      do_sched   <= 1'b0;
      any_armed  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grace <= cfg_wr_data;
      end
      unique case (state)
        mcs_pkg::ST_IDLE: begin
          if (accept) begin
            if (arm_wr) begin
              armed[IDX_W'(in_index)] <= 1'b1;
            end
            if (disarm_wr) begin
              armed[IDX_W'(in_index)] <= 1'b0;
            end
            is_match   <= (s_tuser == mcs_pkg::OP_MATCH);
            do_sched   <= need_scan;
            fired_mask <= '0;
            any_armed  <= 1'b0;
            rd_cnt     <= '0;
            ev_valid   <= 1'b0;
            state      <= need_scan ? mcs_pkg::ST_SCAN : mcs_pkg::ST_EMIT;
          end
        end
        mcs_pkg::ST_SCAN: begin
          ev_valid <= rd_en;
          ev_idx   <= IDX_W'(rd_cnt);
          if (rd_en) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (ev_valid) begin
            if (ev_fire) begin
              armed[ev_idx]      <= 1'b0;
              fired_mask[ev_idx] <= 1'b1;
            end
            if (ev_live && ev_dist <= best) begin
              any_armed <= 1'b1;
            end
            if (ev_idx == LAST_IDX) begin
              state <= mcs_pkg::ST_EMIT;
            end
          end
        end
        mcs_pkg::ST_EMIT: begin
          if (out_load) begin
            if (fired_mask != '0) begin
              fired_mask[first_fired] <= 1'b0;
            end else begin
              if (sched_we) begin
                sched_cmp <= sched_next;
              end
              state <= mcs_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= mcs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= in_now_c;
      lax_q <= in_now_c - grace_c;
      best  <= '1;
      pick  <= '0;
    end else if (state == mcs_pkg::ST_SCAN && ev_valid && ev_live && ev_dist <= best) begin
      best <= ev_dist;
      pick <= rd_data;
    end
  end

  // ----------------------------------------------------------- output register
  logic [mcs_pkg::FIRED_W-1:0] out_entry;
  logic [mcs_pkg::FIELD_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser   <= res_kind;
      out_entry <= mcs_pkg::FIRED_W'(res_entry);
      out_value <= mcs_pkg::FIELD_W'(res_value);
      m_tlast   <= res_last;
    end
  end

  assign m_tdata = {{mcs_pkg::M_PAD_W{1'b0}}, out_value, out_entry};

  // --------------------------------------------------------------- assertions
  // Fired marks only exist while working on a match event.
  assert property (@(posedge clk) disable iff (rst)
    (fired_mask != '0) |-> is_match)
    else $error("fired entries outside a match event");

  // A fired entry result is never the end of a run.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == mcs_pkg::KIND_FIRED) |-> !m_tlast)
    else $error("fired result marked last");

  // Read counter never runs past the table.
  assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= CNT_W'(ENTRIES))
    else $error("table walk overran");

  // A fired entry is disarmed together with the setting of its fired mark.
  assert property (@(posedge clk) disable iff (rst)
    (state == mcs_pkg::ST_SCAN && ev_valid && ev_fire) |=> !armed[$past(ev_idx)])
    else $error("fired entry still armed");

endmodule
